// ----- hw/rtl/ogp_pkg.sv -----
// ============================================================================
// ogp_pkg - shared types and constants of the 4-D occupancy grid store
// Sizes of the cell store, stream word layout, register indexes and the
// structs that pass between the index pipeline, the cell update stage
// and the result queue.
// ============================================================================
package ogp_pkg;

    localparam int CELL_CAPACITY = 65536;
    localparam int IDX_W         = $clog2(CELL_CAPACITY);
    localparam int CELL_W        = 2;
    localparam int COORD_W       = 8;
    localparam int SIZE_W        = 8;

    localparam int IN_DATA_W     = 40;
    localparam int OUT_DATA_W    = 8;
    localparam int RES_W         = 4;

    localparam int RES_DEPTH     = 8;
    localparam int RES_PTR_W     = $clog2(RES_DEPTH);
    localparam int RES_CNT_W     = RES_PTR_W + 1;

    localparam int CFG_IDX_W     = 2;

    typedef logic [CFG_IDX_W-1:0] t_reg_idx;
    localparam t_reg_idx REG_SIZE_X    = 2'd0;
    localparam t_reg_idx REG_SIZE_Y    = 2'd1;
    localparam t_reg_idx REG_SIZE_Z    = 2'd2;
    localparam t_reg_idx REG_SIZE_TIME = 2'd3;

    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    typedef logic [CELL_W-1:0] t_cell;
    localparam t_cell CELL_FREE      = 2'd0;
    localparam t_cell CELL_RESERVED  = 2'd1;
    localparam t_cell CELL_TENTATIVE = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 8'd16;

    typedef struct packed {
        logic [SIZE_W-1:0] sx;
        logic [SIZE_W-1:0] sy;
        logic [SIZE_W-1:0] sz;
        logic [SIZE_W-1:0] st;
    } t_sizes;

    // Cell access request leaving the index pipeline
    typedef struct packed {
        logic             valid;
        logic             func;
        t_cell            new_value;
        logic             oob;
        logic [IDX_W-1:0] addr;
    } t_req;

    // Result of one access, before the result queue
    typedef struct packed {
        logic  valid;
        logic  updated;
        logic  oob;
        t_cell cell_value;
    } t_res;

endpackage

// ----- hw/rtl/ogp_ram.sv -----
// ============================================================================
// ogp_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// A read and a write of the same address in one cycle return the old data.
// ============================================================================
module ogp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/ogp_index.sv -----
// ============================================================================
// ogp_index - bounds check and linear index pipeline
// Three stages, one multiply-add each: a = t*sz + z, b = a*sy + y,
// c = b*sx + x. The last stage drives the request combinationally.
// ============================================================================
module ogp_index
    import ogp_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_func,
    input  t_cell              i_new_value,
    input  logic [COORD_W-1:0] i_x,
    input  logic [COORD_W-1:0] i_y,
    input  logic [COORD_W-1:0] i_z,
    input  logic [COORD_W-1:0] i_t,
    input  t_sizes             i_sizes,
    output t_req               o_req
);

    // stage 1: captured word
    logic               r_v1, r_f1;
    t_cell              r_nv1;
    logic [COORD_W-1:0] r_x1, r_y1, r_z1, r_t1;
    // stage 2
    logic               r_v2, r_f2, r_oob2;
    t_cell              r_nv2;
    logic [COORD_W-1:0] r_x2, r_y2;
    logic [15:0]        r_a2;
    // stage 3
    logic               r_v3, r_f3, r_oob3;
    t_cell              r_nv3;
    logic [COORD_W-1:0] r_x3;
    logic [23:0]        r_b3;

    logic        w_oob1;
    logic [15:0] w_a;
    logic [23:0] w_b;
    logic [31:0] w_c;

    assign w_oob1 = (r_x1 >= i_sizes.sx) || (r_y1 >= i_sizes.sy) ||
                    (r_z1 >= i_sizes.sz) || (r_t1 >= i_sizes.st);
    assign w_a = ({8'd0, r_t1} * {8'd0, i_sizes.sz}) + {8'd0, r_z1};
    assign w_b = ({8'd0, r_a2} * {16'd0, i_sizes.sy}) + {16'd0, r_y2};
    assign w_c = ({8'd0, r_b3} * {24'd0, i_sizes.sx}) + {24'd0, r_x3};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_f1   <= i_func;
        r_nv1  <= i_new_value;
        r_x1   <= i_x;
        r_y1   <= i_y;
        r_z1   <= i_z;
        r_t1   <= i_t;

        r_f2   <= r_f1;
        r_nv2  <= r_nv1;
        r_x2   <= r_x1;
        r_y2   <= r_y1;
        r_oob2 <= w_oob1;
        r_a2   <= w_a;

        r_f3   <= r_f2;
        r_nv3  <= r_nv2;
        r_x3   <= r_x2;
        r_oob3 <= r_oob2;
        r_b3   <= w_b;
    end

    always_comb begin
        o_req.valid     = r_v3;
        o_req.func      = r_f3;
        o_req.new_value = r_nv3;
        o_req.oob       = r_oob3 || (w_c >= 32'(CELL_CAPACITY));
        o_req.addr      = w_c[IDX_W-1:0];
    end

endmodule

// ----- hw/rtl/ogp_cell_rmw.sv -----
// ============================================================================
// ogp_cell_rmw - cell store with read-modify-write and clearing pass
// Issue the read from the incoming request, apply the priority rule in the
// next cycle and write back. Forward the last write to cover the
// read-during-write overlap. After reset, sweep the store to zero.
// ============================================================================
module ogp_cell_rmw
    import ogp_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_req i_req,
    output t_res o_res,
    output logic o_ready
);

    t_req             r_req;
    logic             r_clr_busy;
    logic [IDX_W-1:0] r_clr_addr;
    logic             r_fwd_valid;
    logic [IDX_W-1:0] r_fwd_addr;
    t_cell            r_fwd_data;

    t_cell            w_rdata;
    t_cell            w_old;
    logic             w_do_write;
    logic             w_we;
    logic [IDX_W-1:0] w_waddr;
    t_cell            w_wdata;

    ogp_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_CAPACITY)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (i_req.addr),
        .o_rdata (w_rdata)
    );

    assign w_old = (r_fwd_valid && (r_fwd_addr == r_req.addr)) ? r_fwd_data : w_rdata;

    // Priority: anything nonzero over free, reserved over tentative
    assign w_do_write = r_req.valid && !r_req.oob && (r_req.func == FUNC_WRITE) &&
                        (((w_old == CELL_FREE) && (r_req.new_value != CELL_FREE)) ||
                         ((w_old == CELL_TENTATIVE) && (r_req.new_value == CELL_RESERVED)));

    assign w_we    = r_clr_busy || w_do_write;
    assign w_waddr = r_clr_busy ? r_clr_addr : r_req.addr;
    assign w_wdata = r_clr_busy ? CELL_FREE : r_req.new_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req       <= '0;
            r_clr_busy  <= 1'b1;
            r_clr_addr  <= '0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_req       <= i_req;
            r_fwd_valid <= w_do_write;
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == {IDX_W{1'b1}}) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_addr <= r_req.addr;
        r_fwd_data <= r_req.new_value;
    end

    always_comb begin
        o_res.valid      = r_req.valid;
        o_res.updated    = w_do_write;
        o_res.oob        = r_req.oob;
        o_res.cell_value = r_req.oob ? CELL_FREE : w_old;
    end

    assign o_ready = !r_clr_busy;

endmodule

// ----- hw/rtl/ogp_rfifo.sv -----
// ============================================================================
// ogp_rfifo - result queue
// Small register queue between the update stage and the output stream.
// Admission upstream guarantees it never overflows.
// ============================================================================
module ogp_rfifo
    import ogp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_res                  i_res,
    output logic                  o_valid,
    output logic [OUT_DATA_W-1:0] o_data,
    input  logic                  i_ready
);

    logic [RES_W-1:0]     r_mem [RES_DEPTH];
    logic [RES_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [RES_CNT_W-1:0] r_count;
    logic                 w_pop;

    assign o_valid = (r_count != '0);
    assign w_pop   = o_valid && i_ready;
    assign o_data  = {{(OUT_DATA_W-RES_W){1'b0}}, r_mem[r_rd_ptr]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_res.valid) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= r_count + RES_CNT_W'(i_res.valid) - RES_CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_res.valid) begin
            r_mem[r_wr_ptr] <= {i_res.updated, i_res.oob, i_res.cell_value};
        end
    end

endmodule

// ----- hw/rtl/occupancy_grid_4d_priority_store.sv -----
// ============================================================================
// occupancy_grid_4d_priority_store - 4-D occupancy grid of 2-bit cells
// Read or priority-write one cell of an (x, y, z, time) grid per word.
// ============================================================================
// Usage:
//   Input stream (s_axis): one word per cell access. tuser carries the
//   operation (read / priority write), tdata the coordinates and the value.
//   Output stream (m_axis): one word per access with the old cell value,
//   the out-of-bounds flag and the updated flag, in input order.
//   Config port: write the four size registers (x, y, z, time) with
//   i_cfg_we / i_cfg_idx / i_cfg_data while no access is in flight.
// Timing:
//   From acceptance to o_m_axis_tvalid: the accept edge captures the word, the
//   first two multiply-adds are registered in turn, the RAM read is issued at
//   the final index, and the updated result is pushed into the queue.
//   Throughput is one word per cycle while tready is high; the write-back
//   with last-write forwarding keeps back-to-back accesses to one cell exact.
// Reset:
//   Sizes return to 16. The cell store is swept to zero one cell a cycle,
//   all 65536 cells, with o_s_axis_tready held low until the sweep is done.
// Stall:
//   Results wait in an 8-entry queue; accepted words are counted against
//   it, so tready drops once 8 words are outstanding and no result is lost.
// ============================================================================
module occupancy_grid_4d_priority_store
    import ogp_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // input stream
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,  // coord_x, coord_y, coord_z,
                                                   // coord_time, new_value, pad
    input  logic                  i_s_axis_tuser,  // func
    // output stream
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,  // cell_value, out_of_bounds,
                                                   // updated, pad
    // configuration
    input  logic                  i_cfg_we,
    input  t_reg_idx              i_cfg_idx,
    input  logic [SIZE_W-1:0]     i_cfg_data
);

    t_sizes               r_sizes;
    logic [RES_CNT_W-1:0] r_used;
    logic [RES_CNT_W-1:0] n_used;

    logic w_store_ready;
    logic w_in_acc;
    logic w_out_acc;
    t_req w_req;
    t_res w_res;

    // Size registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sizes <= '{sx: SIZE_RESET, sy: SIZE_RESET, sz: SIZE_RESET, st: SIZE_RESET};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_SIZE_X:    r_sizes.sx <= i_cfg_data;
                REG_SIZE_Y:    r_sizes.sy <= i_cfg_data;
                REG_SIZE_Z:    r_sizes.sz <= i_cfg_data;
                REG_SIZE_TIME: r_sizes.st <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Admit a word only when the result queue is sure to have room for it
    assign o_s_axis_tready = w_store_ready && (r_used < RES_CNT_W'(RES_DEPTH));
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_acc       = o_m_axis_tvalid && i_m_axis_tready;
    assign n_used          = r_used + RES_CNT_W'(w_in_acc) - RES_CNT_W'(w_out_acc);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else begin
            r_used <= n_used;
        end
    end

    ogp_index u_index (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (w_in_acc),
        .i_func      (i_s_axis_tuser),
        .i_new_value (i_s_axis_tdata[33:32]),
        .i_x         (i_s_axis_tdata[7:0]),
        .i_y         (i_s_axis_tdata[15:8]),
        .i_z         (i_s_axis_tdata[23:16]),
        .i_t         (i_s_axis_tdata[31:24]),
        .i_sizes     (r_sizes),
        .o_req       (w_req)
    );

    ogp_cell_rmw u_rmw (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .o_res   (w_res),
        .o_ready (w_store_ready)
    );

    ogp_rfifo u_rfifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_res   (w_res),
        .o_valid (o_m_axis_tvalid),
        .o_data  (o_m_axis_tdata),
        .i_ready (i_m_axis_tready)
    );

endmodule

// ----- hw/rtl/ogp_checker.sv -----
// ============================================================================
// ogp_checker - port-level checks of the occupancy grid store
// Watches the stream ports; bound to the top level below.
// ============================================================================
module ogp_checker
    import ogp_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_s_axis_tvalid,
    input logic                  o_s_axis_tready,
    input logic                  o_m_axis_tvalid,
    input logic                  i_m_axis_tready,
    input logic [OUT_DATA_W-1:0] o_m_axis_tdata
);

    logic [RES_CNT_W:0] r_pending;

    // Count words accepted but not yet answered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + (RES_CNT_W+1)'(i_s_axis_tvalid && o_s_axis_tready)
                                   - (RES_CNT_W+1)'(o_m_axis_tvalid && i_m_axis_tready);
        end
    end

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_s_axis_tready && !o_m_axis_tvalid)
        else $error("ports active right after reset");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (r_pending != '0))
        else $error("result without an outstanding access");

    a_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= (RES_CNT_W+1)'(RES_DEPTH))
        else $error("more accesses outstanding than result slots");

    a_update_rule: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tdata[3] |->
            !o_m_axis_tdata[2] &&
            ((o_m_axis_tdata[1:0] == CELL_FREE) || (o_m_axis_tdata[1:0] == CELL_TENTATIVE)))
        else $error("update reported on a cell that may not change");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output word changed while stalled");

endmodule

bind occupancy_grid_4d_priority_store ogp_checker u_ogp_checker (.*);
